>>> rtl/core/euclidean_gcd_unit_assert.svh
// assertion macros for the euclidean gcd unit
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef EUCLIDEAN_GCD_UNIT_ASSERT_SVH
`define EUCLIDEAN_GCD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EGCD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd unit check failed");
`define EGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcd unit check failed");
`else
`define EGCD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define EGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/egcd_pkg.sv
// shared constants for the euclidean gcd unit: opcodes and default width
// no dependencies
`default_nettype none
package egcd_pkg;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int OPCODE_WIDTH = 2;

   localparam logic [OPCODE_WIDTH-1:0] OPC_REMAINDER = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OPC_SUBTRACT  = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OPC_DIVIDE    = 2'd2;
   localparam logic [OPCODE_WIDTH-1:0] OPC_UNUSED    = 2'd3;
endpackage
`default_nettype wire

>>> rtl/core/euclidean_gcd_unit.sv
// euclidean gcd unit: each remainder step is a check state followed by a shared
// bit-serial restoring divider; the strobe follows the remainder steps of Euclid
// on the operand magnitudes; the next word is taken the cycle the result is shown;
// the receiver cannot stall the strobe; synchronous reset returns the sequencer
// to idle and drops the strobe
`default_nettype none
`include "euclidean_gcd_unit_assert.svh"
module euclidean_gcd_unit
   import egcd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [OPCODE_WIDTH-1:0]      req_opcode,
   input  wire  signed [DATA_WIDTH-1:0] req_first_operand,
   input  wire  signed [DATA_WIDTH-1:0] req_second_operand,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH:0]   rsp_divisor
);
   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [OPCODE_WIDTH-1:0] opcode_ff, opcode_in;
   logic                    sign_a_ff, sign_a_in;
   logic                    sign_b_ff, sign_b_in;
   logic                    parity_ff, parity_in;
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   y_ff, y_in;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]   dvd_ff, dvd_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    strobe_ff, strobe_in;
   logic signed [DATA_WIDTH:0] result_ff, result_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] rem_step;
   logic [DATA_WIDTH-1:0] mag_a;
   logic [DATA_WIDTH-1:0] mag_b;
   logic [DATA_WIDTH:0]   mag_ext;
   logic                  res_sign;

   assign mag_a = req_first_operand[DATA_WIDTH-1] ?
                  (~req_first_operand + 1'b1) : req_first_operand;
   assign mag_b = req_second_operand[DATA_WIDTH-1] ?
                  (~req_second_operand + 1'b1) : req_second_operand;

   // restoring step: shift one dividend bit in, subtract if it fits
   assign shifted  = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign trial    = shifted - {1'b0, y_ff};
   assign rem_step = trial[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

   // final value takes the sign of whichever operand it descends from; OPC_SUBTRACT gives it no sign
   assign mag_ext  = {1'b0, x_ff};
   assign res_sign = (opcode_ff != OPC_SUBTRACT) && (parity_ff ? sign_b_ff : sign_a_ff);

   always_comb begin
      state_in  = state_ff;
      opcode_in = opcode_ff;
      sign_a_in = sign_a_ff;
      sign_b_in = sign_b_ff;
      parity_in = parity_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               opcode_in = req_opcode;
               sign_a_in = req_first_operand[DATA_WIDTH-1];
               sign_b_in = req_second_operand[DATA_WIDTH-1];
               parity_in = 1'b0;
               x_in      = mag_a;
               y_in      = mag_b;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (y_ff == '0) begin
               strobe_in = 1'b1;
               if (opcode_ff == OPC_UNUSED) begin
                  result_in = '0;
               end else if (res_sign) begin
                  result_in = -$signed(mag_ext);
               end else begin
                  result_in = $signed(mag_ext);
               end
               state_in = S_IDLE;
            end else begin
               rem_in   = '0;
               dvd_in   = x_ff;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               x_in      = y_ff;
               y_in      = rem_step;
               parity_in = ~parity_ff;
               state_in  = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      opcode_ff <= opcode_in;
      sign_a_ff <= sign_a_in;
      sign_b_ff <= sign_b_in;
      parity_ff <= parity_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_divisor = result_ff;

   `EGCD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `EGCD_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `EGCD_ASSERT_SAME(a_sub_nonneg, clock, reset,
                     rsp_strobe && (opcode_ff == OPC_SUBTRACT), !rsp_divisor[DATA_WIDTH])
   `EGCD_ASSERT_SAME(a_div_nonzero, clock, reset, state_ff == S_DIV, y_ff != '0)
endmodule
`default_nettype wire
